// ===== src/jsu_pkg.sv =====
// Shared types, codes and character constants for the JSON string unescaper.
package jsu_pkg;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_STR  = 2'd1;
	localparam logic [1:0] MODE_ESC  = 2'd2;
	localparam logic [1:0] MODE_HEX  = 2'd3;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH     = 8'h2f;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0d;
	localparam logic [7:0] CH_LOWER_B   = 8'h62;
	localparam logic [7:0] CH_LOWER_F   = 8'h66;
	localparam logic [7:0] CH_LOWER_N   = 8'h6e;
	localparam logic [7:0] CH_LOWER_R   = 8'h72;
	localparam logic [7:0] CH_LOWER_T   = 8'h74;
	localparam logic [7:0] CH_LOWER_U   = 8'h75;
	localparam logic [7:0] CH_BS_CODE   = 8'h08;
	localparam logic [7:0] CH_FF_CODE   = 8'h0c;
	localparam logic [7:0] CH_LF_CODE   = 8'h0a;

	localparam logic [15:0] CP_ONE_MAX = 16'h007f;
	localparam logic [15:0] CP_TWO_MAX = 16'h07ff;
	localparam logic [7:0]  LEAD_TWO   = 8'hc0;
	localparam logic [7:0]  LEAD_THREE = 8'he0;
	localparam logic [7:0]  CONT_MARK  = 8'h80;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
	} slot_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] hex_cnt;
		logic [15:0] accum;
	} state_t;

	typedef struct packed {
		logic [1:0] count;
		slot_t [2:0] slots;
		state_t nxt;
	} dec_t;

	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b0, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

// ===== src/jsu_decode.sv =====
// Per-byte decode: next state and up to three result slots.
module jsu_decode
	import jsu_pkg::*;
(
	input  logic [7:0] byte_in,
	input  logic       end_of_input,
	input  state_t     cur,
	output dec_t       dec
);

	logic [4:0]  hv;
	logic [15:0] cp;

	assign hv = hex_value(byte_in);
	assign cp = {cur.accum[11:0], hv[3:0]};

	always_comb begin
		dec       = '0;
		dec.nxt   = cur;
		if (end_of_input) begin
			dec.count          = 2'd1;
			dec.slots[0].kind  = KIND_ERR;
			dec.nxt            = '0;
		end else begin
			unique case (cur.mode)
				MODE_IDLE: begin
					if (byte_in == CH_SPACE || (byte_in >= CH_TAB && byte_in <= CH_CR)) begin
						dec.nxt = cur;
					end else if (byte_in == CH_QUOTE) begin
						dec.nxt.mode = MODE_STR;
					end else begin
						dec.count         = 2'd1;
						dec.slots[0].kind = KIND_ERR;
						dec.nxt           = '0;
					end
				end
				MODE_STR: begin
					if (byte_in == CH_QUOTE) begin
						dec.count         = 2'd1;
						dec.slots[0].kind = KIND_DONE;
						dec.nxt           = '0;
					end else if (byte_in < CH_SPACE) begin
						dec.count         = 2'd1;
						dec.slots[0].kind = KIND_ERR;
						dec.nxt           = '0;
					end else if (byte_in == CH_BACKSLASH) begin
						dec.nxt.mode = MODE_ESC;
					end else begin
						dec.count         = 2'd1;
						dec.slots[0].data = byte_in;
						dec.slots[0].kind = KIND_DATA;
					end
				end
				MODE_ESC: begin
					dec.count         = 2'd1;
					dec.slots[0].kind = KIND_DATA;
					dec.nxt.mode      = MODE_STR;
					case (byte_in)
						CH_QUOTE, CH_BACKSLASH, CH_SLASH: dec.slots[0].data = byte_in;
						CH_LOWER_B: dec.slots[0].data = CH_BS_CODE;
						CH_LOWER_F: dec.slots[0].data = CH_FF_CODE;
						CH_LOWER_N: dec.slots[0].data = CH_LF_CODE;
						CH_LOWER_R: dec.slots[0].data = CH_CR;
						CH_LOWER_T: dec.slots[0].data = CH_TAB;
						CH_LOWER_U: begin
							dec.count       = 2'd0;
							dec.nxt.mode    = MODE_HEX;
							dec.nxt.hex_cnt = 2'd0;
							dec.nxt.accum   = '0;
						end
						default: begin
							dec.slots[0].kind = KIND_ERR;
							dec.nxt           = '0;
						end
					endcase
				end
				MODE_HEX: begin
					if (hv[4]) begin
						dec.count         = 2'd1;
						dec.slots[0].kind = KIND_ERR;
						dec.nxt           = '0;
					end else if (cur.hex_cnt == 2'd3) begin
						dec.nxt      = '0;
						dec.nxt.mode = MODE_STR;
						if (cp <= CP_ONE_MAX) begin
							dec.count         = 2'd1;
							dec.slots[0].data = cp[7:0];
						end else if (cp <= CP_TWO_MAX) begin
							dec.count         = 2'd2;
							dec.slots[0].data = LEAD_TWO | {3'b000, cp[10:6]};
							dec.slots[1].data = CONT_MARK | {2'b00, cp[5:0]};
						end else begin
							dec.count         = 2'd3;
							dec.slots[0].data = LEAD_THREE | {4'b0000, cp[15:12]};
							dec.slots[1].data = CONT_MARK | {2'b00, cp[11:6]};
							dec.slots[2].data = CONT_MARK | {2'b00, cp[5:0]};
						end
					end else begin
						dec.nxt.accum   = cp;
						dec.nxt.hex_cnt = cur.hex_cnt + 2'd1;
					end
				end
				default: dec.nxt = '0;
			endcase
		end
	end

endmodule

// ===== src/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------
//  in      | in_valid, in_stall | byte_in, end_of_input
//  out     | out_valid, out_stall | out_byte, kind, last
//
// One input beat per cycle unless in_stall; its first result is presented from the
// single result buffer. A \u escape ending in a three-byte sequence holds that buffer
// until all three slots drain, one slot per cycle unless out_stall is high.
// Reset returns the parser to idle and empties both registers.
// An out stall backs up into the input register and then raises in_stall.
module json_string_unescape_utf8
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] byte_in,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] kind,
	output logic       last
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eoi_s1;
	state_t      state_q;
	logic [1:0]  cnt_q;
	logic [1:0]  idx_q;
	slot_t [2:0] slots_q;
	dec_t        dec;
	logic        buf_free;
	logic        move;
	logic        take;
	logic        is_last;

	jsu_decode u_dec (
		.byte_in      (byte_s1),
		.end_of_input (eoi_s1),
		.cur          (state_q),
		.dec          (dec)
	);

	assign is_last   = (idx_q == cnt_q - 2'd1);
	assign out_valid = (cnt_q != 2'd0);
	assign take      = out_valid && !out_stall;
	assign buf_free  = !out_valid || (take && is_last);
	assign move      = valid_s1 && buf_free;
	assign in_stall  = valid_s1 && !buf_free;

	assign out_byte = slots_q[idx_q].data;
	assign kind     = slots_q[idx_q].kind;
	assign last     = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= byte_in;
			eoi_s1  <= end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			cnt_q   <= 2'd0;
			idx_q   <= 2'd0;
		end else if (move) begin
			state_q <= dec.nxt;
			cnt_q   <= dec.count;
			idx_q   <= 2'd0;
		end else if (take) begin
			if (is_last) begin
				cnt_q <= 2'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			slots_q <= dec.slots;
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the JSON string unescaper, predicting every UTF-8 output beat.
`timescale 1ns / 1ps

module testbench;
	import jsu_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic       last;
	} result_t;

	class unescape_scoreboard;
		result_t     expected_q[$];
		result_t     batch[$];
		logic [1:0]  mode;
		logic [1:0]  hex_cnt;
		logic [15:0] accum;
		int          errors;
		int          live_items;

		function new();
			go_idle();
			errors = 0;
			live_items = 0;
		endfunction

		function void go_idle();
			mode = MODE_IDLE;
			hex_cnt = 2'd0;
			accum = 16'd0;
		endfunction

		function void add(logic [7:0] b, logic [1:0] k);
			result_t item;
			item.data = b;
			item.kind = k;
			item.last = 1'b0;
			batch.insert(batch.size(), item);
		endfunction

		function int digit_value(logic [7:0] c);
			if (c >= "0" && c <= "9") return c - "0";
			if (c >= "a" && c <= "f") return c - "a" + 10;
			if (c >= "A" && c <= "F") return c - "A" + 10;
			return -1;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Advance the unescaper state by one accepted input beat and queue its predicted results.
		function void note_input(logic [7:0] c, logic eoi);
			logic        blank;
			int          d;
			logic [15:0] cp;
			batch.delete();
			blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
			if (eoi || mode != MODE_IDLE || !blank) live_items++;
			if (eoi) begin
				add(8'h00, KIND_ERR);
				go_idle();
			end else begin
				case (mode)
					MODE_IDLE: begin
						if (c == CH_QUOTE) begin
							mode = MODE_STR;
						end else if (!blank) begin
							add(8'h00, KIND_ERR);
							go_idle();
						end
					end
					MODE_STR: begin
						if (c == CH_QUOTE) begin
							add(8'h00, KIND_DONE);
							go_idle();
						end else if (c < CH_SPACE) begin
							add(8'h00, KIND_ERR);
							go_idle();
						end else if (c == CH_BACKSLASH) begin
							mode = MODE_ESC;
						end else begin
							add(c, KIND_DATA);
						end
					end
					MODE_ESC: begin
						mode = MODE_STR;
						case (c)
							CH_LOWER_U: begin
								mode = MODE_HEX;
								hex_cnt = 2'd0;
								accum = 16'd0;
							end
							CH_QUOTE, CH_BACKSLASH, CH_SLASH: add(c, KIND_DATA);
							CH_LOWER_B: add(CH_BS_CODE, KIND_DATA);
							CH_LOWER_F: add(CH_FF_CODE, KIND_DATA);
							CH_LOWER_N: add(CH_LF_CODE, KIND_DATA);
							CH_LOWER_R: add(CH_CR, KIND_DATA);
							CH_LOWER_T: add(CH_TAB, KIND_DATA);
							default: begin
								add(8'h00, KIND_ERR);
								go_idle();
							end
						endcase
					end
					default: begin
						d = digit_value(c);
						if (d < 0) begin
							add(8'h00, KIND_ERR);
							go_idle();
						end else begin
							accum = {accum[11:0], 4'(d)};
							if (hex_cnt == 2'd3) begin
								cp = accum;
								if (cp <= CP_ONE_MAX) begin
									add(cp[7:0], KIND_DATA);
								end else if (cp <= CP_TWO_MAX) begin
									add(LEAD_TWO | {3'b000, cp[10:6]}, KIND_DATA);
									add(CONT_MARK | {2'b00, cp[5:0]}, KIND_DATA);
								end else begin
									add(LEAD_THREE | {4'h0, cp[15:12]}, KIND_DATA);
									add(CONT_MARK | {2'b00, cp[11:6]}, KIND_DATA);
									add(CONT_MARK | {2'b00, cp[5:0]}, KIND_DATA);
								end
								mode = MODE_STR;
								hex_cnt = 2'd0;
								accum = 16'd0;
							end else begin
								hex_cnt = hex_cnt + 2'd1;
							end
						end
					end
				endcase
			end
			if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i]) expected_q.insert(expected_q.size(), batch[i]);
		endfunction

		task report(string what);
			if (errors < 40) $display("%0t mismatch: %s", $time, what);
			errors++;
		endtask

		task check_result(logic [7:0] b, logic [1:0] k, logic l);
			result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected beat byte %02h kind %0d last %0b", b, k, l));
				return;
			end
			want = expected_q.pop_front();
			if (b !== want.data)
				report($sformatf("out_byte %02h, predicted %02h", b, want.data));
			if (k !== want.kind)
				report($sformatf("kind %0d, predicted %0d", k, want.kind));
			if (l !== want.last)
				report($sformatf("last %0b, predicted %0b", l, want.last));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] byte_in = 8'h00;
	logic       end_of_input = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic       last;

	bit steady = 1'b0;
	unescape_scoreboard sb;

	json_string_unescape_utf8 dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_in(byte_in),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.kind(kind),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] v);
		if (v < 4'd10) return 8'("0" + v);
		if ($urandom_range(0, 1) != 0) return 8'("a" + v - 10);
		return 8'("A" + v - 10);
	endfunction

	// Called at a rising edge; returns at the rising edge that takes the beat.
	task automatic send(input logic [7:0] b, input logic eoi);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		byte_in <= b;
		end_of_input <= eoi;
		do @(negedge clk); while (in_stall);
		sb.note_input(b, eoi);
		@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_byte, kind, last);
	end

	initial begin
		int run;
		forever begin
			run = steady ? $urandom_range(20, 60) : $urandom_range(1, 8);
			repeat (run) @(posedge clk);
			if (!steady) begin
				out_stall <= 1'b1;
				repeat (pick_gap() + 1) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		string       text;
		int          base;
		int          pick;
		bit          broken;
		bit          paused;
		logic [7:0]  b;
		logic [15:0] cp;
		sb = new();
		paused = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send(CH_SPACE, 1'b0);
		send(CH_TAB, 1'b0);
		send(CH_QUOTE, 1'b0);
		send(CH_SPACE, 1'b0);
		send(8'hff, 1'b0);
		text = "\\n\\u07FF\\uffff\"";
		for (int i = 0; i < text.len(); i++) send(text[i], 1'b0);
		send(8'h00, 1'b0);
		send(8'hff, 1'b1);
		send(CH_QUOTE, 1'b0);
		send(8'h1f, 1'b0);

		base = sb.live_items;
		while (sb.live_items - base < 160) begin
			if ($urandom_range(0, 7) == 0) steady = !steady;
			if (!paused && sb.live_items - base >= 80) begin
				wait_drained();
				paused = 1'b1;
			end
			repeat ($urandom_range(0, 2)) begin
				pick = $urandom_range(0, 5);
				send((pick == 0) ? CH_SPACE : 8'(CH_TAB + pick - 1), 1'b0);
			end
			if ($urandom_range(0, 15) == 0) begin
				send(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
				continue;
			end
			send(CH_QUOTE, 1'b0);
			broken = 1'b0;
			repeat ($urandom_range(0, 8)) begin
				if (!broken) begin
					pick = $urandom_range(0, 99);
					if (pick < 40) begin
						do b = 8'($urandom_range(32, 255));
						while (b == CH_QUOTE || b == CH_BACKSLASH);
						send(b, 1'b0);
					end else if (pick < 62) begin
						send(CH_BACKSLASH, 1'b0);
						case ($urandom_range(0, 7))
							0: b = CH_QUOTE;
							1: b = CH_BACKSLASH;
							2: b = CH_SLASH;
							3: b = CH_LOWER_B;
							4: b = CH_LOWER_F;
							5: b = CH_LOWER_N;
							6: b = CH_LOWER_R;
							default: b = CH_LOWER_T;
						endcase
						send(b, 1'b0);
					end else if (pick < 90) begin
						send(CH_BACKSLASH, 1'b0);
						send(CH_LOWER_U, 1'b0);
						case ($urandom_range(0, 3))
							0: cp = 16'($urandom_range(16'h0000, 16'h007f));
							1: cp = 16'($urandom_range(16'h0080, 16'h07ff));
							2: cp = 16'($urandom_range(16'h0800, 16'hffff));
							default: cp = 16'($urandom_range(16'hd800, 16'hdfff));
						endcase
						for (int i = 3; i >= 0; i--) send(hex_char(cp[i * 4 +: 4]), 1'b0);
					end else begin
						broken = 1'b1;
						case ($urandom_range(0, 4))
							0: send(8'($urandom_range(0, 31)), 1'b0);
							1: begin
								send(CH_BACKSLASH, 1'b0);
								do b = 8'($urandom_range(0, 255));
								while (b inside {CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_LOWER_B,
									CH_LOWER_F, CH_LOWER_N, CH_LOWER_R, CH_LOWER_T, CH_LOWER_U});
								send(b, 1'b0);
							end
							2: begin
								send(CH_BACKSLASH, 1'b0);
								send(CH_LOWER_U, 1'b0);
								repeat ($urandom_range(0, 3))
									send(hex_char(4'($urandom_range(0, 15))), 1'b0);
								do b = 8'($urandom_range(0, 255));
								while (sb.digit_value(b) >= 0);
								send(b, 1'b0);
							end
							3: send(8'($urandom_range(0, 255)), 1'b1);
							default: send(8'($urandom_range(0, 255)), $urandom_range(0, 1) != 0);
						endcase
					end
				end
			end
			if (!broken) begin
				if ($urandom_range(0, 11) == 0) send(8'($urandom_range(0, 255)), 1'b1);
				else send(CH_QUOTE, 1'b0);
			end
		end

		steady = 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
